>>> rtl/sm83_alu_with_flags_top_defines.svh
// Assertion macros shared by the SM83 ALU checker.
// No dependencies; include once per file that asserts.
`ifndef SM83_ALU_WITH_FLAGS_TOP_DEFINES_SVH
`define SM83_ALU_WITH_FLAGS_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SM83_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sm83 alu: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SM83_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sm83 alu: check failed");

`endif

>>> rtl/sm83_pkg.sv
// Package for the SM83 ALU: operation codes, flag positions, stage structs.
// No dependencies.
`default_nettype none

package sm83_pkg;

    typedef enum logic [4:0] {
        CMD_ADD   = 5'd0,
        CMD_ADC   = 5'd1,
        CMD_SUB   = 5'd2,
        CMD_SBC   = 5'd3,
        CMD_AND   = 5'd4,
        CMD_XOR   = 5'd5,
        CMD_OR    = 5'd6,
        CMD_CP    = 5'd7,
        CMD_INC   = 5'd8,
        CMD_DEC   = 5'd9,
        CMD_RLC   = 5'd10,
        CMD_RRC   = 5'd11,
        CMD_RL    = 5'd12,
        CMD_RR    = 5'd13,
        CMD_SLA   = 5'd14,
        CMD_SRA   = 5'd15,
        CMD_SWAP  = 5'd16,
        CMD_SRL   = 5'd17,
        CMD_BIT   = 5'd18,
        CMD_RES   = 5'd19,
        CMD_SET   = 5'd20,
        CMD_RLCA  = 5'd21,
        CMD_RRCA  = 5'd22,
        CMD_RLA   = 5'd23,
        CMD_RRA   = 5'd24,
        CMD_DAA   = 5'd25,
        CMD_CPL   = 5'd26,
        CMD_CCF   = 5'd27,
        CMD_SCF   = 5'd28,
        CMD_ADD16 = 5'd29,
        CMD_ADDSP = 5'd30
    } cmd_t;

    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    localparam logic [7:0] DAA_LO   = 8'h06;
    localparam logic [7:0] DAA_HI   = 8'h60;
    localparam logic [7:0] DAA_LIM  = 8'h99;
    localparam logic [3:0] DAA_NLIM = 4'h9;

    // Decode stage output: adder operands plus what later stages need.
    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] x;
        logic [15:0] y;
        logic        cin;
        logic [7:0]  a;
        logic [2:0]  bidx;
        logic [3:0]  fl;
        logic        daa_c;
    } s1_t;

    // Execute stage output: raw sum with carries, logic/shift result.
    typedef struct packed {
        cmd_t        cmd;
        logic [16:0] sum;
        logic        c4;
        logic        c8;
        logic        c12;
        logic [7:0]  lres;
        logic        co;
        logic        bz;
        logic [3:0]  fl;
        logic        daa_c;
    } s2_t;

endpackage

`default_nettype wire

>>> rtl/sm83_alu_with_flags_top.sv
// Top level of the SM83 ALU: three register stages, decode -> exec -> retire.
// Depends on sm83_pkg, sm83_decode, sm83_exec, sm83_retire.
//
//   channel | signals                                           | dir
//   --------+---------------------------------------------------+-----
//   in      | in_valid, in_ready, command, operand_a, operand_b, | in
//           | bit_index, flags_in                               |
//   out     | out_valid, out_ready, result, flags_out, write_back | out
//
// One item per cycle while out_ready holds; an accepted item passes the decode,
// exec and retire registers in turn, and out_valid rises once it is in retire.
// Stage one forms the adder operands, stage two runs the 17-bit adder and the
// logic/shift unit, stage three builds flags and holds the output register.
// Reset clears the stage valid bits only; the pipeline is empty afterward.
// A stalled output holds its item; each stage refills as soon as it empties.
`default_nettype none

module sm83_alu_with_flags_top
    import sm83_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire logic [4:0]  command,
    input  wire logic [15:0] operand_a,
    input  wire logic [15:0] operand_b,
    input  wire logic [2:0]  bit_index,
    input  wire logic [3:0]  flags_in,
    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic [15:0] result,
    output      logic [3:0]  flags_out,
    output      logic        write_back
);

    logic s1_valid;
    logic s1_ready;
    s1_t  s1_data;
    logic s2_valid;
    logic s2_ready;
    s2_t  s2_data;

    sm83_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .bit_index (bit_index),
        .flags_in  (flags_in),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    sm83_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    sm83_retire u_retire (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s2_valid),
        .in_ready   (s2_ready),
        .in_data    (s2_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result),
        .flags_out  (flags_out),
        .write_back (write_back)
    );

endmodule

`default_nettype wire

>>> rtl/sm83_decode.sv
// Stage 1 of the SM83 ALU: decode the operation and form adder operands.
// Depends on sm83_pkg.
`default_nettype none

module sm83_decode
    import sm83_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire logic [4:0]  command,
    input  wire logic [15:0] operand_a,
    input  wire logic [15:0] operand_b,
    input  wire logic [2:0]  bit_index,
    input  wire logic [3:0]  flags_in,
    output      logic        out_valid,
    input  wire logic        out_ready,
    output      s1_t         out_data
);

    logic       valid_reg;
    s1_t        data_reg;
    s1_t        data_next;
    cmd_t       cmd;
    logic [7:0] a;
    logic [7:0] b;
    logic       cin;
    logic       nin;
    logic       hin;
    logic       cor_lo;
    logic       cor_hi;
    logic [7:0] cor;

    assign cmd = cmd_t'(command);
    assign a   = operand_a[7:0];
    assign b   = operand_b[7:0];
    assign cin = flags_in[FLAG_C];
    assign nin = flags_in[FLAG_N];
    assign hin = flags_in[FLAG_H];

    // Decimal adjust correction, decided on the incoming accumulator.
    assign cor_lo = hin || (!nin && (a[3:0] > DAA_NLIM));
    assign cor_hi = cin || (!nin && (a > DAA_LIM));
    assign cor    = (cor_lo ? DAA_LO : 8'h00) | (cor_hi ? DAA_HI : 8'h00);

    always_comb
    begin
        data_next.cmd   = cmd;
        data_next.x     = {8'h00, a};
        data_next.y     = 16'h0000;
        data_next.cin   = 1'b0;
        data_next.a     = a;
        data_next.bidx  = bit_index;
        data_next.fl    = flags_in;
        data_next.daa_c = cor_hi;
        case (cmd)
            CMD_ADD, CMD_AND, CMD_XOR, CMD_OR:
            begin
                data_next.y = {8'h00, b};
            end
            CMD_ADC:
            begin
                data_next.y   = {8'h00, b};
                data_next.cin = cin;
            end
            // subtract as a + ~b + 1, borrow shows as a missing carry
            CMD_SUB, CMD_CP:
            begin
                data_next.y   = {8'h00, ~b};
                data_next.cin = 1'b1;
            end
            CMD_SBC:
            begin
                data_next.y   = {8'h00, ~b};
                data_next.cin = ~cin;
            end
            CMD_INC:
            begin
                data_next.cin = 1'b1;
            end
            CMD_DEC:
            begin
                data_next.y = 16'h00ff;
            end
            CMD_DAA:
            begin
                data_next.y   = {8'h00, (nin ? ~cor : cor)};
                data_next.cin = nin;
            end
            CMD_ADD16:
            begin
                data_next.x = operand_a;
                data_next.y = operand_b;
            end
            CMD_ADDSP:
            begin
                data_next.x = operand_a;
                data_next.y = {{8{b[7]}}, b};
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

>>> rtl/sm83_exec.sv
// Stage 2 of the SM83 ALU: 17-bit add with nibble carries, logic and shifts.
// Depends on sm83_pkg.
`default_nettype none

module sm83_exec
    import sm83_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output      logic in_ready,
    input  wire s1_t  in_data,
    output      logic out_valid,
    input  wire logic out_ready,
    output      s2_t  out_data
);

    logic       valid_reg;
    s2_t        data_reg;
    s2_t        data_next;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] mask;
    logic       cin;

    assign a    = in_data.a;
    assign b    = in_data.y[7:0];
    assign cin  = in_data.fl[FLAG_C];
    assign mask = 8'h01 << in_data.bidx;

    always_comb
    begin
        data_next.cmd   = in_data.cmd;
        data_next.sum   = {1'b0, in_data.x} + {1'b0, in_data.y} + {16'h0000, in_data.cin};
        // carry into a bit position: sum bit xor both operand bits
        data_next.c4    = data_next.sum[4] ^ in_data.x[4] ^ in_data.y[4];
        data_next.c8    = data_next.sum[8] ^ in_data.x[8] ^ in_data.y[8];
        data_next.c12   = data_next.sum[12] ^ in_data.x[12] ^ in_data.y[12];
        data_next.bz    = !a[in_data.bidx];
        data_next.fl    = in_data.fl;
        data_next.daa_c = in_data.daa_c;
        data_next.lres  = 8'h00;
        data_next.co    = 1'b0;
        case (in_data.cmd)
            CMD_AND:  data_next.lres = a & b;
            CMD_XOR:  data_next.lres = a ^ b;
            CMD_OR:   data_next.lres = a | b;
            CMD_RLC, CMD_RLCA:
            begin
                data_next.lres = {a[6:0], a[7]};
                data_next.co   = a[7];
            end
            CMD_RRC, CMD_RRCA:
            begin
                data_next.lres = {a[0], a[7:1]};
                data_next.co   = a[0];
            end
            CMD_RL, CMD_RLA:
            begin
                data_next.lres = {a[6:0], cin};
                data_next.co   = a[7];
            end
            CMD_RR, CMD_RRA:
            begin
                data_next.lres = {cin, a[7:1]};
                data_next.co   = a[0];
            end
            CMD_SLA:
            begin
                data_next.lres = {a[6:0], 1'b0};
                data_next.co   = a[7];
            end
            CMD_SRA:
            begin
                data_next.lres = {a[7], a[7:1]};
                data_next.co   = a[0];
            end
            CMD_SWAP: data_next.lres = {a[3:0], a[7:4]};
            CMD_SRL:
            begin
                data_next.lres = {1'b0, a[7:1]};
                data_next.co   = a[0];
            end
            CMD_RES:  data_next.lres = a & ~mask;
            CMD_SET:  data_next.lres = a | mask;
            CMD_CPL:  data_next.lres = ~a;
            default:
            begin
            end
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

>>> rtl/sm83_retire.sv
// Stage 3 of the SM83 ALU: result select, flag build, output register.
// Depends on sm83_pkg.
`default_nettype none

module sm83_retire
    import sm83_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire s2_t         in_data,
    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic [15:0] result,
    output      logic [3:0]  flags_out,
    output      logic        write_back
);

    logic        valid_reg;
    logic [15:0] result_reg;
    logic [15:0] result_next;
    logic [3:0]  flags_reg;
    logic [3:0]  flags_next;
    logic        wb_reg;
    logic        wb_next;
    logic        zs;
    logic        zl;
    logic        zin;
    logic        nin;
    logic        cin;

    assign zs  = (in_data.sum[7:0] == 8'h00);
    assign zl  = (in_data.lres == 8'h00);
    assign zin = in_data.fl[FLAG_Z];
    assign nin = in_data.fl[FLAG_N];
    assign cin = in_data.fl[FLAG_C];

    // flags_next is built as {Z, N, H, C}
    always_comb
    begin
        result_next = 16'h0000;
        flags_next  = in_data.fl;
        wb_next     = 1'b1;
        case (in_data.cmd)
            CMD_ADD, CMD_ADC:
            begin
                result_next = {8'h00, in_data.sum[7:0]};
                flags_next  = {zs, 1'b0, in_data.c4, in_data.c8};
            end
            CMD_SUB, CMD_SBC:
            begin
                result_next = {8'h00, in_data.sum[7:0]};
                flags_next  = {zs, 1'b1, !in_data.c4, !in_data.c8};
            end
            CMD_CP:
            begin
                result_next = {8'h00, in_data.sum[7:0]};
                flags_next  = {zs, 1'b1, !in_data.c4, !in_data.c8};
                wb_next     = 1'b0;
            end
            CMD_AND:
            begin
                result_next = {8'h00, in_data.lres};
                flags_next  = {zl, 1'b0, 1'b1, 1'b0};
            end
            CMD_XOR, CMD_OR:
            begin
                result_next = {8'h00, in_data.lres};
                flags_next  = {zl, 1'b0, 1'b0, 1'b0};
            end
            CMD_INC:
            begin
                result_next = {8'h00, in_data.sum[7:0]};
                flags_next  = {zs, 1'b0, in_data.c4, cin};
            end
            CMD_DEC:
            begin
                result_next = {8'h00, in_data.sum[7:0]};
                flags_next  = {zs, 1'b1, !in_data.c4, cin};
            end
            CMD_RLC, CMD_RRC, CMD_RL, CMD_RR, CMD_SLA, CMD_SRA, CMD_SWAP, CMD_SRL:
            begin
                result_next = {8'h00, in_data.lres};
                flags_next  = {zl, 1'b0, 1'b0, in_data.co};
            end
            // accumulator rotates always clear Z
            CMD_RLCA, CMD_RRCA, CMD_RLA, CMD_RRA:
            begin
                result_next = {8'h00, in_data.lres};
                flags_next  = {1'b0, 1'b0, 1'b0, in_data.co};
            end
            CMD_BIT:
            begin
                flags_next = {in_data.bz, 1'b0, 1'b1, cin};
                wb_next    = 1'b0;
            end
            CMD_RES, CMD_SET:
            begin
                result_next = {8'h00, in_data.lres};
            end
            CMD_DAA:
            begin
                result_next = {8'h00, in_data.sum[7:0]};
                flags_next  = {zs, nin, 1'b0, in_data.daa_c};
            end
            CMD_CPL:
            begin
                result_next = {8'h00, in_data.lres};
                flags_next  = {zin, 1'b1, 1'b1, cin};
            end
            CMD_CCF:
            begin
                flags_next = {zin, 1'b0, 1'b0, !cin};
                wb_next    = 1'b0;
            end
            CMD_SCF:
            begin
                flags_next = {zin, 1'b0, 1'b0, 1'b1};
                wb_next    = 1'b0;
            end
            CMD_ADD16:
            begin
                result_next = in_data.sum[15:0];
                flags_next  = {zin, 1'b0, in_data.c12, in_data.sum[16]};
            end
            CMD_ADDSP:
            begin
                result_next = in_data.sum[15:0];
                flags_next  = {1'b0, 1'b0, in_data.c4, in_data.c8};
            end
            default:
            begin
                wb_next = 1'b0;
            end
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            result_reg <= result_next;
            flags_reg  <= flags_next;
            wb_reg     <= wb_next;
        end
    end

    assign out_valid  = valid_reg;
    assign result     = result_reg;
    assign flags_out  = flags_reg;
    assign write_back = wb_reg;

endmodule

`default_nettype wire

>>> rtl/sm83_checker.sv
// Port-level checks for the SM83 ALU, bound to the top level.
// Depends on sm83_alu_with_flags_top_defines.svh.
`default_nettype none

`include "sm83_alu_with_flags_top_defines.svh"

module sm83_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [4:0]  command,
    input wire logic [15:0] operand_a,
    input wire logic [15:0] operand_b,
    input wire logic [2:0]  bit_index,
    input wire logic [3:0]  flags_in,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] result,
    input wire logic [3:0]  flags_out,
    input wire logic        write_back
);

    // Hold a stalled input item.
    `SM83_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready,
        in_valid && $stable(command) && $stable(operand_a) && $stable(operand_b) && $stable(bit_index) && $stable(flags_in))

    // Hold a stalled result.
    `SM83_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(result) && $stable(flags_out) && $stable(write_back))

    // A draining output frees the whole pipeline for a new item.
    `SM83_ASSERT_NOW(a_ready_flow, clk, rst_n, out_ready, in_ready)

    // Only compare leaves a nonzero result that is not written back.
    `SM83_ASSERT_NOW(a_cp_only, clk, rst_n, out_valid && !write_back && (result != 16'h0000),
        flags_out[2] && (result[15:8] == 8'h00))

    // Wide results come from the 16-bit adds, which always clear N.
    `SM83_ASSERT_NOW(a_wide_n, clk, rst_n, out_valid && (result[15:8] != 8'h00),
        write_back && !flags_out[2])

endmodule

bind sm83_alu_with_flags_top sm83_checker u_sm83_checker (.*);

`default_nettype wire

>>> verif/sm83_alu_with_flags_checker.sv
`timescale 1ns / 100ps
// Checker for the SM83 ALU: watches both channels, predicts each result and compares.
// Depends on sm83_pkg for operation codes, flag positions and decimal-adjust constants.

module sm83_alu_with_flags_checker
    import sm83_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [4:0]  command,
    input  logic [15:0] operand_a,
    input  logic [15:0] operand_b,
    input  logic [2:0]  bit_index,
    input  logic [3:0]  flags_in,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] result,
    input  logic [3:0]  flags_out,
    input  logic        write_back,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic [15:0] value;
        logic [3:0]  flags;
        logic        wb;
    } alu_res_t;

    alu_res_t due_results[$];
    alu_res_t want;

    function automatic logic [3:0] pack_flags(logic z, logic n, logic h, logic c);
        logic [3:0] f;
        f = '0;
        f[FLAG_Z] = z;
        f[FLAG_N] = n;
        f[FLAG_H] = h;
        f[FLAG_C] = c;
        return f;
    endfunction

    function automatic alu_res_t alu_compute(logic [4:0] op, logic [15:0] a16,
                                             logic [15:0] b16, logic [2:0] idx,
                                             logic [3:0] fl);
        alu_res_t    r;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  res8;
        logic [7:0]  cor;
        logic        cin;
        logic        cy;
        logic        co;
        logic [8:0]  s9;
        logic [4:0]  s5;
        logic [12:0] s13;
        logic [16:0] s17;
        logic [15:0] ext;
        a = a16[7:0];
        b = b16[7:0];
        cin = fl[FLAG_C];
        r.value = '0;
        r.flags = fl;
        r.wb = 1'b1;
        case (op)
            CMD_ADD, CMD_ADC:
            begin
                cy = (op == CMD_ADC) ? cin : 1'b0;
                s9 = {1'b0, a} + {1'b0, b} + {8'h00, cy};
                s5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cy};
                r.value = {8'h00, s9[7:0]};
                r.flags = pack_flags(s9[7:0] == 8'h00, 1'b0, s5[4], s9[8]);
            end
            CMD_SUB, CMD_SBC, CMD_CP:
            begin
                cy = (op == CMD_SBC) ? cin : 1'b0;
                res8 = a - b - {7'h00, cy};
                r.value = {8'h00, res8};
                r.flags = pack_flags(res8 == 8'h00, 1'b1,
                                     {1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'h0, cy}),
                                     {1'b0, a} < ({1'b0, b} + {8'h00, cy}));
                if (op == CMD_CP)
                    r.wb = 1'b0;
            end
            CMD_AND:
            begin
                res8 = a & b;
                r.value = {8'h00, res8};
                r.flags = pack_flags(res8 == 8'h00, 1'b0, 1'b1, 1'b0);
            end
            CMD_XOR, CMD_OR:
            begin
                res8 = (op == CMD_XOR) ? (a ^ b) : (a | b);
                r.value = {8'h00, res8};
                r.flags = pack_flags(res8 == 8'h00, 1'b0, 1'b0, 1'b0);
            end
            CMD_INC:
            begin
                res8 = a + 8'h01;
                r.value = {8'h00, res8};
                r.flags = pack_flags(res8 == 8'h00, 1'b0, res8[3:0] == 4'h0, cin);
            end
            CMD_DEC:
            begin
                res8 = a - 8'h01;
                r.value = {8'h00, res8};
                r.flags = pack_flags(res8 == 8'h00, 1'b1, res8[3:0] == 4'hf, cin);
            end
            CMD_RLC, CMD_RRC, CMD_RL, CMD_RR, CMD_SLA, CMD_SRA, CMD_SWAP, CMD_SRL,
            CMD_RLCA, CMD_RRCA, CMD_RLA, CMD_RRA:
            begin
                case (op)
                    CMD_RLC, CMD_RLCA: begin co = a[7]; res8 = {a[6:0], a[7]}; end
                    CMD_RRC, CMD_RRCA: begin co = a[0]; res8 = {a[0], a[7:1]}; end
                    CMD_RL, CMD_RLA:   begin co = a[7]; res8 = {a[6:0], cin};  end
                    CMD_RR, CMD_RRA:   begin co = a[0]; res8 = {cin, a[7:1]};  end
                    CMD_SLA:           begin co = a[7]; res8 = {a[6:0], 1'b0}; end
                    CMD_SRA:           begin co = a[0]; res8 = {a[7], a[7:1]}; end
                    CMD_SWAP:          begin co = 1'b0; res8 = {a[3:0], a[7:4]}; end
                    default:           begin co = a[0]; res8 = {1'b0, a[7:1]}; end
                endcase
                r.value = {8'h00, res8};
                // accumulator forms always clear Z
                r.flags = pack_flags((op < CMD_RLCA) && (res8 == 8'h00), 1'b0, 1'b0, co);
            end
            CMD_BIT:
            begin
                r.wb = 1'b0;
                r.flags = pack_flags(!a[idx], 1'b0, 1'b1, cin);
            end
            CMD_RES:
                r.value = {8'h00, a & ~(8'h01 << idx)};
            CMD_SET:
                r.value = {8'h00, a | (8'h01 << idx)};
            CMD_DAA:
            begin
                cor = 8'h00;
                cy = cin;
                if (fl[FLAG_H] || (!fl[FLAG_N] && a[3:0] > DAA_NLIM))
                    cor = cor | DAA_LO;
                if (cin || (!fl[FLAG_N] && a > DAA_LIM))
                begin
                    cor = cor | DAA_HI;
                    cy = 1'b1;
                end
                res8 = fl[FLAG_N] ? (a - cor) : (a + cor);
                r.value = {8'h00, res8};
                r.flags = pack_flags(res8 == 8'h00, fl[FLAG_N], 1'b0, cy);
            end
            CMD_CPL:
            begin
                r.value = {8'h00, ~a};
                r.flags = pack_flags(fl[FLAG_Z], 1'b1, 1'b1, cin);
            end
            CMD_CCF, CMD_SCF:
            begin
                r.wb = 1'b0;
                r.flags = pack_flags(fl[FLAG_Z], 1'b0, 1'b0, (op == CMD_SCF) ? 1'b1 : !cin);
            end
            CMD_ADD16:
            begin
                s17 = {1'b0, a16} + {1'b0, b16};
                s13 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
                r.value = s17[15:0];
                r.flags = pack_flags(fl[FLAG_Z], 1'b0, s13[12], s17[16]);
            end
            CMD_ADDSP:
            begin
                ext = {{8{b[7]}}, b};
                s9 = {1'b0, a16[7:0]} + {1'b0, b};
                s5 = {1'b0, a16[3:0]} + {1'b0, b[3:0]};
                r.value = a16 + ext;
                r.flags = pack_flags(1'b0, 1'b0, s5[4], s9[8]);
            end
            default:
                r.wb = 1'b0;
        endcase
        return r;
    endfunction

    task automatic compare_field(string name, logic [15:0] exp_val, logic [15:0] got_val);
        if (exp_val !== got_val)
        begin
            $error("%s mismatch: expected %h, got %h", name, exp_val, got_val);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_results.delete();
            pending <= 0;
        end
        else
        begin
            // retire before predicting so a result never meets its own item
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("unexpected item: result %h, flags_out %h", result, flags_out);
                    errors++;
                end
                else
                begin
                    want = due_results.pop_front();
                    compare_field("result", want.value, result);
                    compare_field("flags_out", {12'h000, want.flags}, {12'h000, flags_out});
                    compare_field("write_back", {15'h0000, want.wb}, {15'h0000, write_back});
                end
            end
            if (in_valid && in_ready)
                due_results.push_back(alu_compute(command, operand_a, operand_b,
                                                  bit_index, flags_in));
            pending <= due_results.size();
        end
    end

endmodule

>>> verif/sm83_alu_with_flags_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the SM83 ALU: clock, reset, operation stimulus and verdict.
// Depends on sm83_pkg, sm83_alu_with_flags_top and sm83_alu_with_flags_checker.

module sm83_alu_with_flags_top_tb;
    import sm83_pkg::*;

    localparam logic [4:0] CMD_UNUSED  = 5'd31;
    localparam int         RANDOM_OPS  = 650;
    localparam int         HOLD_AFTER  = 150;
    localparam int         HOLD_CYCLES = 300;
    localparam int         IDLE_LIMIT  = 3000;
    localparam int         DRAIN       = 8;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [4:0]  command;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic [3:0]  flags_in;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] result;
    logic [3:0]  flags_out;
    logic        write_back;
    int          errors;
    int          pending;
    int          idle_cycles;
    int          send_calm;

    sm83_alu_with_flags_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .operand_a  (operand_a),
        .operand_b  (operand_b),
        .bit_index  (bit_index),
        .flags_in   (flags_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result),
        .flags_out  (flags_out),
        .write_back (write_back)
    );

    sm83_alu_with_flags_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .operand_a  (operand_a),
        .operand_b  (operand_b),
        .bit_index  (bit_index),
        .flags_in   (flags_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result),
        .flags_out  (flags_out),
        .write_back (write_back),
        .errors     (errors),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
    function automatic int idle_len(inout int calm_left);
        int pick;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
        begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 88)
            return $urandom_range(1, 3);
        else if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Bias operands toward byte and word corners.
    function automatic logic [15:0] pick_operand();
        logic [7:0] corner;
        case ($urandom_range(0, 6))
            0: corner = 8'h00;
            1: corner = 8'hff;
            2: corner = 8'h0f;
            3: corner = 8'h80;
            4: corner = 8'h7f;
            5: corner = 8'h99;
            default: corner = 8'h9a;
        endcase
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hffff;
            2, 3: return {8'($urandom), corner};
            4: return {4'($urandom), 12'hfff};
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic issue_op(input logic [4:0] op, input logic [15:0] a, input logic [15:0] b,
                            input logic [2:0] idx, input logic [3:0] fl);
        int gap;
        gap = idle_len(send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        command   <= op;
        operand_a <= a;
        operand_b <= b;
        bit_index <= idx;
        flags_in  <= fl;
        do @(posedge clk); while (!in_ready);
    endtask

    initial
    begin : stimulus
        logic [4:0] op;
        in_valid = 1'b0;
        command = '0;
        operand_a = '0;
        operand_b = '0;
        bit_index = '0;
        flags_in = '0;
        send_calm = 0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every code with operands and flags at their extremes
        for (int c = CMD_ADD; c <= CMD_UNUSED; c++)
            issue_op(5'(c), c[0] ? 16'hffff : 16'h0000, c[1] ? 16'hffff : 16'h0000,
                     c[2] ? 3'd7 : 3'd0, c[3] ? 4'hf : 4'h0);
        issue_op(CMD_ADD, 16'h000f, 16'h0001, 3'd0, 4'h0);
        issue_op(CMD_CP, 16'h0042, 16'h0042, 3'd0, 4'h0);
        issue_op(CMD_BIT, 16'h007f, 16'h0000, 3'd7, 4'h1);
        issue_op(CMD_RLA, 16'h0080, 16'h0000, 3'd0, 4'h0);
        issue_op(CMD_DAA, 16'h009a, 16'h0000, 3'd0, 4'h0);
        issue_op(CMD_DAA, 16'h0000, 16'h0000, 3'd0, 4'h7);
        issue_op(CMD_ADD16, 16'h0fff, 16'h0001, 3'd0, 4'h8);
        issue_op(CMD_ADDSP, 16'h00ff, 16'h0081, 3'd0, 4'hf);

        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            op = ($urandom_range(0, 99) < 2) ? CMD_UNUSED : 5'($urandom_range(CMD_ADD, CMD_ADDSP));
            issue_op(op, pick_operand(), pick_operand(), 3'($urandom), 4'($urandom));
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (DRAIN) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin : receiver
        int stall_left;
        int taken;
        int calm;
        bit held_off;
        stall_left = 0;
        taken = 0;
        calm = 0;
        held_off = 1'b0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                taken++;
            if (!held_off && taken >= HOLD_AFTER)
            begin
                // hold off long enough to fill the pipe and back up the input
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                stall_left = idle_len(calm);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
        else
            idle_cycles <= 0;
    end

endmodule
